/* hdl/sbdt_pkg.sv */
// Shared types and constants for the suspend blocker deadline table.
// No dependencies.
package sbdt_pkg;

    localparam logic [2:0] MODE_START  = 3'd0;
    localparam logic [2:0] MODE_STOP   = 3'd1;
    localparam logic [2:0] MODE_SWEEP  = 3'd2;
    localparam logic [2:0] MODE_QUERY  = 3'd3;
    localparam logic [2:0] MODE_FREEZE = 3'd4;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_FROZEN    = 3'd1;
    localparam logic [2:0] STAT_FULL      = 3'd2;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [2:0] STAT_REFUSED   = 3'd4;

    localparam logic REG_MAX_DURATION = 1'b0;

    localparam logic [30:0] DEFAULT_MAX_DURATION_MS = 31'(15 * 60 * 1000);
    localparam logic [30:0] REMAIN_MAX              = 31'h7FFF_FFFF;

    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
        logic report;
    } sbdt_cmd_t;

    typedef struct packed {
        logic last_addr;
    } sbdt_sts_t;

endpackage

/* hdl/sbdt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sbdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* hdl/sbdt_ctrl.sv */
// Sequencer for the deadline table: accept, table walk, drain, commit, report.
// Depends on sbdt_pkg.
module sbdt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sbdt_pkg::sbdt_sts_t sts,
    output sbdt_pkg::sbdt_cmd_t cmd
);
    import sbdt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DRAIN  = 5'b00100,
        S_COMMIT = 5'b01000,
        S_REPORT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.issue = 1'b1;
                if (sts.last_addr)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                cmd.report = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

/* hdl/sbdt_dp.sv */
// Datapath: item registers, tag and deadline RAMs, valid bits, walk statistics.
// Depends on sbdt_pkg and sbdt_ram.
module sbdt_dp #(
    parameter int TABLE_DEPTH = 16,
    parameter int TAG_BITS    = 32,
    parameter int TIME_BITS   = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sbdt_pkg::sbdt_cmd_t cmd,
    output sbdt_pkg::sbdt_sts_t sts,
    input  logic [2:0]          mode,
    input  logic                thaw_flag,
    input  logic [31:0]         activity_tag,
    input  logic [30:0]         hold_ms,
    input  logic [47:0]         time_ms,
    input  logic [30:0]         max_hold_ms,
    output logic                done,
    output logic [2:0]          status,
    output logic [4:0]          active_count,
    output logic                can_sleep,
    output logic [30:0]         max_remaining_ms,
    output logic [4:0]          removed_count
);
    import sbdt_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);

    logic [2:0]           mode_reg;
    logic                 thaw_reg;
    logic [TAG_BITS-1:0]  tag_reg;
    logic [30:0]          dur_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [TIME_BITS-1:0] dl_reg;

    logic [IDX_W-1:0]       addr_reg,       addr_next;
    logic                   rd_vld_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [TABLE_DEPTH-1:0] valid_reg,      valid_next;
    logic                   frozen_reg,     frozen_next;
    logic                   matched_reg,    matched_next;
    logic                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]       free_slot_reg,  free_slot_next;
    logic [COUNT_W-1:0]     count_reg,      count_next;
    logic [COUNT_W-1:0]     removed_reg,    removed_next;
    logic [TIME_BITS-1:0]   best_reg,       best_next;
    logic [2:0]             stat_reg,       stat_next;

    logic        done_reg;
    logic [2:0]  status_out_reg;
    logic [4:0]  active_out_reg;
    logic        sleep_out_reg;
    logic [30:0] remain_out_reg;
    logic [4:0]  removed_out_reg;

    logic [TAG_BITS-1:0]  tag_rd;
    logic [TIME_BITS-1:0] dl_rd;
    logic [63:0]          tag_ext;
    logic [63:0]          time_ext;
    logic [30:0]          dur_clamped;
    logic [TIME_BITS:0]   dl_sum;
    logic [TIME_BITS-1:0] dl_sat;
    logic [TIME_BITS-1:0] diff;
    logic [30:0]          remain;

    logic is_start, is_stop, is_sweep, is_freeze;
    logic rd_v, hit, expired, kill, live, store, ram_we;

    assign tag_ext     = 64'(activity_tag);
    assign time_ext    = 64'(time_ms);
    assign dur_clamped = (hold_ms > max_hold_ms) ? max_hold_ms : hold_ms;

    assign dl_sum = {1'b0, now_reg} + (TIME_BITS + 1)'(dur_reg);
    assign dl_sat = dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];

    assign is_start  = (mode_reg == MODE_START);
    assign is_stop   = (mode_reg == MODE_STOP);
    assign is_sweep  = (mode_reg == MODE_SWEEP);
    assign is_freeze = (mode_reg == MODE_FREEZE);

    assign rd_v    = valid_reg[rd_idx_reg];
    assign hit     = rd_vld_reg && rd_v && (is_start || is_stop) && !matched_reg
                     && (tag_rd == tag_reg);
    assign expired = (dl_rd < now_reg);
    assign kill    = rd_vld_reg && rd_v && is_sweep && expired;
    assign live    = rd_vld_reg && rd_v && !hit && !expired;
    assign store   = is_start && !frozen_reg && free_found_reg;
    assign ram_we  = cmd.commit && store;

    assign sts.last_addr = (addr_reg == IDX_W'(TABLE_DEPTH - 1));

    // remaining time, saturated to 31 bits
    assign diff   = best_reg - now_reg;
    assign remain = (count_reg == '0) ? '0 :
                    ((diff > TIME_BITS'(REMAIN_MAX)) ? REMAIN_MAX : diff[30:0]);

    sbdt_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_slot_reg),
        .wdata (tag_reg),
        .raddr (addr_reg),
        .rdata (tag_rd)
    );

    sbdt_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_dl_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_slot_reg),
        .wdata (dl_reg),
        .raddr (addr_reg),
        .rdata (dl_rd)
    );

    always_comb
    begin
        addr_next       = addr_reg;
        valid_next      = valid_reg;
        frozen_next     = frozen_reg;
        matched_next    = matched_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        count_next      = count_reg;
        removed_next    = removed_reg;
        best_next       = best_reg;
        stat_next       = stat_reg;

        if (cmd.load)
        begin
            addr_next       = '0;
            matched_next    = 1'b0;
            free_found_next = 1'b0;
            count_next      = '0;
            removed_next    = '0;
            best_next       = '0;
        end

        if (cmd.issue)
        begin
            addr_next = addr_reg + 1'b1;
        end

        if (hit)
        begin
            valid_next[rd_idx_reg] = 1'b0;
            matched_next           = 1'b1;
        end
        if (kill)
        begin
            valid_next[rd_idx_reg] = 1'b0;
            removed_next           = removed_reg + 1'b1;
        end
        if (rd_vld_reg && !free_found_reg && (!rd_v || hit))
        begin
            free_found_next = 1'b1;
            free_slot_next  = rd_idx_reg;
        end
        if (live)
        begin
            count_next = count_reg + 1'b1;
            if (dl_rd > best_reg)
            begin
                best_next = dl_rd;
            end
        end

        if (cmd.commit)
        begin
            stat_next = STAT_OK;
            if (is_start)
            begin
                if (frozen_reg)
                begin
                    stat_next = STAT_FROZEN;
                end
                else if (!free_found_reg)
                begin
                    stat_next = STAT_FULL;
                end
            end
            else if (is_stop && !matched_reg)
            begin
                stat_next = STAT_NOT_FOUND;
            end
            else if (is_freeze)
            begin
                if (thaw_reg)
                begin
                    frozen_next = 1'b0;
                end
                else if (count_reg != '0)
                begin
                    stat_next = STAT_REFUSED;
                end
                else
                begin
                    frozen_next = 1'b1;
                end
            end

            if (store)
            begin
                valid_next[free_slot_reg] = 1'b1;
                count_next                = count_reg + 1'b1;
                if (dl_reg > best_reg)
                begin
                    best_next = dl_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg   <= '0;
            rd_vld_reg <= 1'b0;
            valid_reg  <= '0;
            frozen_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            addr_reg   <= addr_next;
            rd_vld_reg <= cmd.issue;
            valid_reg  <= valid_next;
            frozen_reg <= frozen_next;
            done_reg   <= cmd.report;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            thaw_reg <= thaw_flag;
            tag_reg  <= tag_ext[TAG_BITS-1:0];
            dur_reg  <= dur_clamped;
            now_reg  <= time_ext[TIME_BITS-1:0];
        end
        dl_reg         <= dl_sat;
        rd_idx_reg     <= addr_reg;
        matched_reg    <= matched_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        count_reg      <= count_next;
        removed_reg    <= removed_next;
        best_reg       <= best_next;
        stat_reg       <= stat_next;
        if (cmd.report)
        begin
            status_out_reg  <= stat_reg;
            active_out_reg  <= 5'(count_reg);
            sleep_out_reg   <= (count_reg == '0);
            remain_out_reg  <= remain;
            removed_out_reg <= 5'(removed_reg);
        end
    end

    assign done             = done_reg;
    assign status           = status_out_reg;
    assign active_count     = active_out_reg;
    assign can_sleep        = sleep_out_reg;
    assign max_remaining_ms = remain_out_reg;
    assign removed_count    = removed_out_reg;
endmodule

/* hdl/suspend_blocker_deadline_table.sv */
// Top level of the suspend blocker deadline table: APB register, sequencer, datapath.
// Depends on sbdt_pkg, sbdt_ctrl, sbdt_dp (and sbdt_ram below it).
//
//   channel   handshake                    fields
//   -------   --------------------------   ---------------------------------------
//   item in   start && !busy               mode, thaw_flag, activity_tag, hold_ms,
//                                          time_ms
//   result    done (one cycle)             status, active_count, can_sleep,
//                                          max_remaining_ms, removed_count
//   config    psel&penable&pwrite&pready   paddr, pwdata (hold cap at 0x0)
//
// An accepted item runs through the walk over the tag and deadline RAMs, one
// entry per cycle, then the drain, commit and report states; done is registered
// from the report state. busy stays high from acceptance until done; the next
// item may start in the cycle done is shown. Reset clears the valid bits and
// the freeze; no clearing pass is needed. Results cannot be held off.
module suspend_blocker_deadline_table #(
    parameter int TABLE_DEPTH = 16,
    parameter int TAG_BITS    = 32,
    parameter int TIME_BITS   = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic        thaw_flag,
    input  logic [31:0] activity_tag,
    input  logic [30:0] hold_ms,
    input  logic [47:0] time_ms,
    output logic        done,
    output logic [2:0]  status,
    output logic [4:0]  active_count,
    output logic        can_sleep,
    output logic [30:0] max_remaining_ms,
    output logic [4:0]  removed_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sbdt_pkg::*;

    sbdt_cmd_t   cmd;
    sbdt_sts_t   sts;
    logic [30:0] max_dur_reg;
    logic [30:0] max_dur_next;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_DURATION);
    assign max_dur_next = cfg_wr ? pwdata[30:0] : max_dur_reg;
    assign prdata = (paddr[2] == REG_MAX_DURATION) ? {1'b0, max_dur_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dur_reg <= DEFAULT_MAX_DURATION_MS;
        end
        else
        begin
            max_dur_reg <= max_dur_next;
        end
    end

    sbdt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    sbdt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TAG_BITS    (TAG_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .mode             (mode),
        .thaw_flag        (thaw_flag),
        .activity_tag     (activity_tag),
        .hold_ms          (hold_ms),
        .time_ms          (time_ms),
        .max_hold_ms      (max_dur_reg),
        .done             (done),
        .status           (status),
        .active_count     (active_count),
        .can_sleep        (can_sleep),
        .max_remaining_ms (max_remaining_ms),
        .removed_count    (removed_count)
    );

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without an item in flight");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.issue, cmd.commit, cmd.report}))
        else $error("overlapping sequencer commands");

    a_sleep_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (done && can_sleep) |-> (max_remaining_ms == '0))
        else $error("remaining time reported with nothing unexpired");

    a_sweep_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (removed_count != '0)) |-> (status == STAT_OK))
        else $error("removals reported with a failing status");
`endif
endmodule
